FILE: rtl/core/assert_macros.svh
// assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/tsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsv_pkg
// shared types and constants for the tar stream validator
// ----------------------------------------------------------------------------
package tsv_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned OFF_W       = 9;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_DATA   = 3'd1,
        PH_PAD    = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_HALT   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENTRY   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        F_NONE      = 4'd0,
        F_CHECKSUM  = 4'd1,
        F_NAME      = 4'd2,
        F_ENTRIES   = 4'd3,
        F_SIZE      = 4'd4,
        F_DIR_SIZE  = 4'd5,
        F_TYPE      = 4'd6,
        F_TRUNC     = 4'd7,
        F_NO_END    = 4'd8,
        F_TRAIL     = 4'd9
    } fault_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_FIVE  = 8'h35;

    localparam logic [19:0] MAX_ENTRIES_RST = 20'd100000;
    localparam logic [29:0] MAX_BYTES_RST   = 30'd536870912;

    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_MAX_BYTES   = 1'b1;

    typedef struct packed {
        kind_t       kind;
        logic        is_dir;
        logic [29:0] length;
        logic [19:0] number;
        logic [7:0]  value;
        logic        final_byte;
        fault_t      fault;
    } result_t;

endpackage

FILE: rtl/core/tsv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsv_front
// parses the archive byte stream and emits a result for the beats that produce one
// ----------------------------------------------------------------------------
module tsv_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    input  logic [19:0]         max_entries,
    input  logic [29:0]         max_bytes,
    input  logic                q_ready,
    output logic                q_push,
    output tsv_pkg::result_t    q_data
);

    logic [8:0]             off_reg, off_next;
    tsv_pkg::phase_t        phase_reg, phase_next;
    logic [1:0]             zrun_reg, zrun_next;
    logic                   allz_reg, allz_next;
    logic [16:0]            sum_reg, sum_next;
    logic [35:0]            oct_reg, oct_next;
    logic [1:0]             octph_reg, octph_next;
    logic                   octdig_reg, octdig_next;
    logic                   octbad_reg, octbad_next;
    logic [35:0]            size_reg, size_next;
    logic                   sizebad_reg, sizebad_next;
    logic [23:0]            ssum_reg, ssum_next;
    logic                   sumbad_reg, sumbad_next;
    logic                   nend_reg, nend_next;
    logic                   nblank_reg, nblank_next;
    logic [7:0]             type_reg, type_next;
    logic [29:0]            rem_reg, rem_next;
    logic [19:0]            ecnt_reg, ecnt_next;
    logic [29:0]            scnt_reg, scnt_next;

    logic                   fire;
    logic                   emit;
    tsv_pkg::result_t       res;
    tsv_pkg::fault_t        fault;
    tsv_pkg::fault_t        hfault;
    logic                   in_oct;
    logic [1:0]             ph_w;
    logic [35:0]            oct_w;
    logic                   dig_w, bad_w;
    logic                   is_digit;
    logic                   allz_w;
    logic [16:0]            sum_w;
    logic                   nblank_w;
    logic                   nend_w;
    logic [7:0]             type_w;
    logic [35:0]            size_w;
    logic                   sizebad_w;
    logic [23:0]            ssum_w;
    logic                   sumbad_w;
    logic [8:0]             off_inc;

    assign in_ready = q_ready;
    assign fire     = in_valid & in_ready;
    assign q_push   = fire & emit;
    assign q_data   = res;
    assign is_digit = (in_byte >= tsv_pkg::CH_ZERO) && (in_byte <= tsv_pkg::CH_SEVEN);
    assign off_inc  = off_reg + 9'd1;

    always_comb
    begin
        in_oct = ((off_reg >= 9'd124) && (off_reg < 9'd136))
              || ((off_reg >= 9'd148) && (off_reg < 9'd156));
        ph_w  = octph_reg;
        oct_w = oct_reg;
        dig_w = octdig_reg;
        bad_w = octbad_reg;
        if (off_reg == 9'd124 || off_reg == 9'd148)
        begin
            ph_w  = 2'd0;
            oct_w = '0;
            dig_w = 1'b0;
            bad_w = 1'b0;
        end
        if (in_oct)
        begin
            if (ph_w == 2'd0 && !(in_byte == tsv_pkg::CH_NUL || in_byte == tsv_pkg::CH_SPACE))
                ph_w = 2'd1;
            if (ph_w == 2'd1 && (in_byte == tsv_pkg::CH_NUL || in_byte == tsv_pkg::CH_SPACE))
                ph_w = 2'd2;
            else if (ph_w == 2'd1 && !is_digit)
            begin
                bad_w = 1'b1;
                ph_w  = 2'd2;
            end
            else if (ph_w == 2'd1)
            begin
                oct_w = {oct_w[32:0], 3'b000} + {33'd0, in_byte[2:0]};
                dig_w = 1'b1;
            end
        end
        sum_w = sum_reg + (((off_reg >= 9'd148) && (off_reg < 9'd156))
                ? 17'd32 : {9'd0, in_byte});
        allz_w = allz_reg & (in_byte == 8'd0);
        nblank_w = nblank_reg;
        nend_w   = nend_reg;
        if (off_reg < 9'd100 && !nend_reg)
        begin
            if (in_byte == 8'd0)
                nend_w = 1'b1;
            else if (in_byte != tsv_pkg::CH_SPACE)
                nblank_w = 1'b1;
        end
        size_w    = (off_reg == 9'd135) ? oct_w : size_reg;
        sizebad_w = (off_reg == 9'd135) ? (bad_w | ~dig_w) : sizebad_reg;
        ssum_w    = (off_reg == 9'd155) ? oct_w[23:0] : ssum_reg;
        sumbad_w  = (off_reg == 9'd155) ? (bad_w | ~dig_w) : sumbad_reg;
        type_w    = (off_reg == 9'd156) ? in_byte : type_reg;
    end

    always_comb
    begin
        if (sumbad_w || ({7'd0, sum_w} != ssum_w))
            hfault = tsv_pkg::F_CHECKSUM;
        else if (!nblank_w)
            hfault = tsv_pkg::F_NAME;
        else if (ecnt_reg >= max_entries)
            hfault = tsv_pkg::F_ENTRIES;
        else if (sizebad_w)
            hfault = tsv_pkg::F_SIZE;
        else if (size_w > {6'd0, max_bytes})
            hfault = tsv_pkg::F_TRUNC;
        else if (in_end && size_w != 36'd0)
            hfault = tsv_pkg::F_TRUNC;
        else if (type_w == tsv_pkg::CH_FIVE && size_w != 36'd0)
            hfault = tsv_pkg::F_DIR_SIZE;
        else if (type_w != tsv_pkg::CH_NUL && type_w != tsv_pkg::CH_ZERO
                 && type_w != tsv_pkg::CH_FIVE)
            hfault = tsv_pkg::F_TYPE;
        else if (in_end)
            hfault = tsv_pkg::F_NO_END;
        else
            hfault = tsv_pkg::F_NONE;
    end

    always_comb
    begin
        off_next     = off_reg;
        phase_next   = phase_reg;
        zrun_next    = zrun_reg;
        allz_next    = allz_reg;
        sum_next     = sum_reg;
        oct_next     = oct_reg;
        octph_next   = octph_reg;
        octdig_next  = octdig_reg;
        octbad_next  = octbad_reg;
        size_next    = size_reg;
        sizebad_next = sizebad_reg;
        ssum_next    = ssum_reg;
        sumbad_next  = sumbad_reg;
        nend_next    = nend_reg;
        nblank_next  = nblank_reg;
        type_next    = type_reg;
        rem_next     = rem_reg;
        ecnt_next    = ecnt_reg;
        scnt_next    = scnt_reg;
        fault        = tsv_pkg::F_NONE;
        emit         = 1'b0;
        res          = '0;
        if (fire)
        begin
            if (phase_reg == tsv_pkg::PH_HALT)
            begin
            end
            else if (scnt_reg >= max_bytes)
                fault = tsv_pkg::F_TRAIL;
            else
            begin
                scnt_next = scnt_reg + 30'd1;
                if (phase_reg != tsv_pkg::PH_TRAIL)
                    off_next = off_inc;
                case (phase_reg)
                    tsv_pkg::PH_HEADER:
                    begin
                        sum_next     = sum_w;
                        allz_next    = allz_w;
                        nblank_next  = nblank_w;
                        nend_next    = nend_w;
                        oct_next     = oct_w;
                        octph_next   = ph_w;
                        octdig_next  = dig_w;
                        octbad_next  = bad_w;
                        size_next    = size_w;
                        sizebad_next = sizebad_w;
                        ssum_next    = ssum_w;
                        sumbad_next  = sumbad_w;
                        type_next    = type_w;
                        if (off_reg == 9'd511)
                        begin
                            if (allz_w)
                            begin
                                if (zrun_reg != 2'd0)
                                begin
                                    zrun_next  = 2'd2;
                                    phase_next = tsv_pkg::PH_TRAIL;
                                    if (in_end)
                                    begin
                                        emit     = 1'b1;
                                        res.kind = tsv_pkg::KIND_DONE;
                                    end
                                end
                                else
                                begin
                                    zrun_next = 2'd1;
                                    if (in_end)
                                        fault = tsv_pkg::F_NO_END;
                                end
                            end
                            else
                            begin
                                zrun_next = 2'd0;
                                fault     = hfault;
                                if (hfault == tsv_pkg::F_NONE)
                                begin
                                    emit       = 1'b1;
                                    res.kind   = tsv_pkg::KIND_ENTRY;
                                    res.is_dir = (type_w == tsv_pkg::CH_FIVE);
                                    res.length = size_w[29:0];
                                    res.number = ecnt_reg;
                                    ecnt_next  = ecnt_reg + 20'd1;
                                    if (size_w != 36'd0)
                                    begin
                                        rem_next   = size_w[29:0];
                                        phase_next = tsv_pkg::PH_DATA;
                                    end
                                end
                            end
                            sum_next    = '0;
                            allz_next   = 1'b1;
                            nblank_next = 1'b0;
                            nend_next   = 1'b0;
                            oct_next    = '0;
                            octph_next  = 2'd0;
                            octdig_next = 1'b0;
                            octbad_next = 1'b0;
                        end
                        else if (in_end)
                            fault = tsv_pkg::F_NO_END;
                    end
                    tsv_pkg::PH_DATA:
                    begin
                        emit             = 1'b1;
                        res.kind         = tsv_pkg::KIND_PAYLOAD;
                        res.number       = ecnt_reg - 20'd1;
                        res.value        = in_byte;
                        res.final_byte   = (rem_reg == 30'd1);
                        if (rem_reg != 30'd0)
                            rem_next = rem_reg - 30'd1;
                        if (rem_reg <= 30'd1)
                            phase_next = (off_inc == 9'd0) ? tsv_pkg::PH_HEADER
                                                           : tsv_pkg::PH_PAD;
                        if (in_end)
                            fault = (phase_next == tsv_pkg::PH_HEADER)
                                    ? tsv_pkg::F_NO_END : tsv_pkg::F_TRUNC;
                    end
                    tsv_pkg::PH_PAD:
                    begin
                        if (off_inc == 9'd0)
                            phase_next = tsv_pkg::PH_HEADER;
                        if (in_end)
                            fault = (off_inc == 9'd0)
                                    ? tsv_pkg::F_NO_END : tsv_pkg::F_TRUNC;
                    end
                    default:
                    begin
                        if (in_byte != 8'd0)
                            fault = tsv_pkg::F_TRAIL;
                        else if (in_end)
                        begin
                            emit     = 1'b1;
                            res.kind = tsv_pkg::KIND_DONE;
                        end
                    end
                endcase
            end
            if (fault != tsv_pkg::F_NONE)
            begin
                emit       = 1'b1;
                res        = '0;
                res.kind   = tsv_pkg::KIND_ERROR;
                res.fault  = fault;
                phase_next = tsv_pkg::PH_HALT;
            end
            if (in_end)
            begin
                off_next     = '0;
                phase_next   = tsv_pkg::PH_HEADER;
                zrun_next    = '0;
                allz_next    = 1'b1;
                sum_next     = '0;
                oct_next     = '0;
                octph_next   = 2'd0;
                octdig_next  = 1'b0;
                octbad_next  = 1'b0;
                size_next    = '0;
                sizebad_next = 1'b0;
                ssum_next    = '0;
                sumbad_next  = 1'b0;
                nend_next    = 1'b0;
                nblank_next  = 1'b0;
                type_next    = '0;
                rem_next     = '0;
                ecnt_next    = '0;
                scnt_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg     <= '0;
            phase_reg   <= tsv_pkg::PH_HEADER;
            zrun_reg    <= '0;
            allz_reg    <= 1'b1;
            sum_reg     <= '0;
            oct_reg     <= '0;
            octph_reg   <= '0;
            octdig_reg  <= 1'b0;
            octbad_reg  <= 1'b0;
            size_reg    <= '0;
            sizebad_reg <= 1'b0;
            ssum_reg    <= '0;
            sumbad_reg  <= 1'b0;
            nend_reg    <= 1'b0;
            nblank_reg  <= 1'b0;
            type_reg    <= '0;
            rem_reg     <= '0;
            ecnt_reg    <= '0;
            scnt_reg    <= '0;
        end
        else
        begin
            off_reg     <= off_next;
            phase_reg   <= phase_next;
            zrun_reg    <= zrun_next;
            allz_reg    <= allz_next;
            sum_reg     <= sum_next;
            oct_reg     <= oct_next;
            octph_reg   <= octph_next;
            octdig_reg  <= octdig_next;
            octbad_reg  <= octbad_next;
            size_reg    <= size_next;
            sizebad_reg <= sizebad_next;
            ssum_reg    <= ssum_next;
            sumbad_reg  <= sumbad_next;
            nend_reg    <= nend_next;
            nblank_reg  <= nblank_next;
            type_reg    <= type_next;
            rem_reg     <= rem_next;
            ecnt_reg    <= ecnt_next;
            scnt_reg    <= scnt_next;
        end
    end

endmodule

FILE: rtl/core/tsv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsv_queue
// two-entry result queue between parser and output port
// ----------------------------------------------------------------------------
module tsv_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                push_ready,
    input  tsv_pkg::result_t    push_data,
    output logic                pop_valid,
    input  logic                pop,
    output tsv_pkg::result_t    pop_data
);

    tsv_pkg::result_t   mem_reg [2];
    logic               wp_reg, wp_next;
    logic               rp_reg, rp_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rp_reg];
    assign do_pop     = pop & pop_valid;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

endmodule

FILE: rtl/core/tar_stream_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_stream_validator_core
// ustar archive byte stream checker with entry records and payload passthrough
// ----------------------------------------------------------------------------
// Takes one archive byte per clock while the queue has room. Each input beat is
// parsed combinationally and its result, if any, enters a two-entry queue that
// drives the output port, so a byte is accepted every cycle while the output
// keeps up; the queue absorbs a stall of up to two results. A result is
// registered in the queue before it reaches the output port.
module tar_stream_validator_core
#(
    parameter int unsigned CFG_IDX_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,    // stream_byte
    input  logic                    s_tlast,    // stream_end
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [63:0]             m_tdata,    // entry_is_directory, entry_length,
                                                // entry_number, payload_value, fault_code
    output logic                    m_tlast,    // payload_final
    output logic [1:0]              m_tuser,    // result_kind
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [29:0]             cfg_data
);

    logic [19:0]        max_ent_reg;
    logic [29:0]        max_bytes_reg;
    logic               q_ready;
    logic               q_push;
    tsv_pkg::result_t   q_in;
    tsv_pkg::result_t   q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ent_reg   <= tsv_pkg::MAX_ENTRIES_RST;
            max_bytes_reg <= tsv_pkg::MAX_BYTES_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_W'(tsv_pkg::CFG_MAX_ENTRIES))
                max_ent_reg <= cfg_data[19:0];
            else if (cfg_index == CFG_IDX_W'(tsv_pkg::CFG_MAX_BYTES))
                max_bytes_reg <= cfg_data;
        end
    end

    tsv_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_end      (s_tlast),
        .max_entries (max_ent_reg),
        .max_bytes   (max_bytes_reg),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    tsv_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_ready),
        .push_data  (q_in),
        .pop_valid  (m_tvalid),
        .pop        (m_tready),
        .pop_data   (q_out)
    );

    assign m_tuser = q_out.kind;
    assign m_tlast = q_out.final_byte;
    assign m_tdata = {1'b0, q_out.fault, q_out.value, q_out.number,
                      q_out.length, q_out.is_dir};

endmodule

FILE: rtl/core/tsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsv_checker
// port-level checks for the tar stream validator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsv_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser
);

    `CHK_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    `CHK_IMPLY(a_err_code, clk, rst_n, m_tvalid && m_tuser == tsv_pkg::KIND_ERROR, m_tdata[62:59] != 4'd0, "error beat without fault code")
    `CHK_IMPLY(a_last_kind, clk, rst_n, m_tvalid && m_tlast, m_tuser == tsv_pkg::KIND_PAYLOAD, "last mark on non-payload beat")
    `CHK_IMPLY(a_ok_code, clk, rst_n, m_tvalid && m_tuser != tsv_pkg::KIND_ERROR, m_tdata[62:59] == 4'd0, "fault code on non-error beat")

endmodule

bind tar_stream_validator_core tsv_checker u_tsv_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: bench/tar_stream_validator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_stream_validator_core_tb
// self-checking bench for the tar stream validator core
// ----------------------------------------------------------------------------
// Builds ustar archives byte by byte (well-formed ones with random content,
// broken headers, early ends, trailing data and plain noise), runs them through
// the core under random stalls on both sides, and compares every output beat
// with a cycle-free behavioral predictor of the archive checker.
module tar_stream_validator_core_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [29:0] cfg_data;

    tar_stream_validator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [19:0]      lim_entries;
    logic [29:0]      lim_bytes;
    logic [8:0]       pr_offset;
    tsv_pkg::phase_t  pr_phase;
    logic [1:0]       pr_zero_run;
    logic             pr_all_zero;
    logic [16:0]      pr_hdr_sum;
    logic [35:0]      pr_oct_acc;
    logic [3:0]       pr_oct_stat;
    logic [35:0]      pr_size;
    logic             pr_size_bad;
    logic [23:0]      pr_stored_sum;
    logic             pr_sum_bad;
    logic [1:0]       pr_name;
    logic [7:0]       pr_type;
    logic [29:0]      pr_remaining;
    logic [19:0]      pr_entries;
    logic [29:0]      pr_stream_cnt;

    tsv_pkg::result_t expected_q[$];
    logic [7:0]       hdr[512];
    int               mismatches;
    int               beats_in;
    int               beats_out;
    int               archives;
    int               idle_cycles;
    int               out_stall;
    bit               calm;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------- predictor ----------------
    task automatic clear_header_locals();
        pr_hdr_sum  = '0;
        pr_all_zero = 1'b1;
        pr_name     = '0;
        pr_oct_acc  = '0;
        pr_oct_stat = '0;
    endtask

    task automatic clear_stream();
        clear_header_locals();
        pr_offset     = '0;
        pr_phase      = tsv_pkg::PH_HEADER;
        pr_zero_run   = '0;
        pr_size       = '0;
        pr_size_bad   = 1'b0;
        pr_stored_sum = '0;
        pr_sum_bad    = 1'b0;
        pr_type       = '0;
        pr_remaining  = '0;
        pr_entries    = '0;
        pr_stream_cnt = '0;
    endtask

    task automatic octal_digit(input logic [7:0] c);
        logic [1:0] ph;
        ph = pr_oct_stat[1:0];
        if (ph == 2'd0)
        begin
            if (c == tsv_pkg::CH_NUL || c == tsv_pkg::CH_SPACE)
                return;
            ph = 2'd1;
        end
        if (ph == 2'd1)
        begin
            if (c == tsv_pkg::CH_NUL || c == tsv_pkg::CH_SPACE)
                ph = 2'd2;
            else if (c < tsv_pkg::CH_ZERO || c > tsv_pkg::CH_SEVEN)
            begin
                pr_oct_stat[3] = 1'b1;
                ph = 2'd2;
            end
            else
            begin
                pr_oct_acc = (pr_oct_acc << 3) + 36'(c - tsv_pkg::CH_ZERO);
                pr_oct_stat[2] = 1'b1;
            end
        end
        pr_oct_stat[1:0] = ph;
    endtask

    function automatic logic octal_bad();
        return pr_oct_stat[3] || !pr_oct_stat[2];
    endfunction

    task automatic header_byte(input logic [8:0] off, input logic [7:0] c);
        pr_hdr_sum = pr_hdr_sum + ((off >= 148 && off < 156) ? 17'd32 : 17'(c));
        if (c != 0)
            pr_all_zero = 1'b0;
        if (off < 100 && !pr_name[0])
        begin
            if (c == tsv_pkg::CH_NUL)
                pr_name[0] = 1'b1;
            else if (c != tsv_pkg::CH_SPACE)
                pr_name[1] = 1'b1;
        end
        if ((off >= 124 && off < 136) || (off >= 148 && off < 156))
        begin
            if (off == 124 || off == 148)
            begin
                pr_oct_acc  = '0;
                pr_oct_stat = '0;
            end
            octal_digit(c);
            if (off == 135)
            begin
                pr_size     = pr_oct_acc;
                pr_size_bad = octal_bad();
            end
            if (off == 155)
            begin
                pr_stored_sum = pr_oct_acc[23:0];
                pr_sum_bad    = octal_bad();
            end
        end
        if (off == 156)
            pr_type = c;
    endtask

    function automatic tsv_pkg::fault_t header_verdict(input bit fin);
        if (pr_sum_bad || 24'(pr_hdr_sum) != pr_stored_sum) return tsv_pkg::F_CHECKSUM;
        if (!pr_name[1]) return tsv_pkg::F_NAME;
        if (pr_entries >= lim_entries) return tsv_pkg::F_ENTRIES;
        if (pr_size_bad) return tsv_pkg::F_SIZE;
        if (pr_size > 36'(lim_bytes)) return tsv_pkg::F_TRUNC;
        if (fin && pr_size != 0) return tsv_pkg::F_TRUNC;
        if (pr_type == tsv_pkg::CH_FIVE && pr_size != 0) return tsv_pkg::F_DIR_SIZE;
        if (pr_type != tsv_pkg::CH_NUL && pr_type != tsv_pkg::CH_ZERO
            && pr_type != tsv_pkg::CH_FIVE) return tsv_pkg::F_TYPE;
        if (fin) return tsv_pkg::F_NO_END;
        return tsv_pkg::F_NONE;
    endfunction

    task automatic predict_byte(input logic [7:0] c, input bit fin);
        tsv_pkg::result_t r;
        bit               have;
        tsv_pkg::fault_t  f;
        logic [8:0]       off;
        r    = '0;
        have = 1'b0;
        f    = tsv_pkg::F_NONE;
        if (pr_phase == tsv_pkg::PH_HALT)
        begin
        end
        else if (pr_stream_cnt >= lim_bytes)
            f = tsv_pkg::F_TRAIL;
        else
        begin
            pr_stream_cnt = pr_stream_cnt + 30'd1;
            off = pr_offset;
            if (pr_phase != tsv_pkg::PH_TRAIL)
                pr_offset = off + 9'd1;
            case (pr_phase)
                tsv_pkg::PH_HEADER:
                begin
                    header_byte(off, c);
                    if (off == 9'd511)
                    begin
                        if (pr_all_zero)
                        begin
                            if (pr_zero_run < 2)
                                pr_zero_run = pr_zero_run + 2'd1;
                            if (pr_zero_run >= 2)
                            begin
                                pr_phase = tsv_pkg::PH_TRAIL;
                                if (fin)
                                begin
                                    r.kind = tsv_pkg::KIND_DONE;
                                    have = 1'b1;
                                end
                            end
                            else if (fin)
                                f = tsv_pkg::F_NO_END;
                        end
                        else
                        begin
                            pr_zero_run = '0;
                            f = header_verdict(fin);
                            if (f == tsv_pkg::F_NONE)
                            begin
                                r.kind   = tsv_pkg::KIND_ENTRY;
                                r.is_dir = (pr_type == tsv_pkg::CH_FIVE);
                                r.length = pr_size[29:0];
                                r.number = pr_entries;
                                have = 1'b1;
                                pr_entries = pr_entries + 20'd1;
                                if (pr_size != 0)
                                begin
                                    pr_remaining = pr_size[29:0];
                                    pr_phase = tsv_pkg::PH_DATA;
                                end
                            end
                        end
                        clear_header_locals();
                    end
                    else if (fin)
                        f = tsv_pkg::F_NO_END;
                end
                tsv_pkg::PH_DATA:
                begin
                    r.kind       = tsv_pkg::KIND_PAYLOAD;
                    r.number     = pr_entries - 20'd1;
                    r.value      = c;
                    r.final_byte = (pr_remaining == 30'd1);
                    have = 1'b1;
                    if (pr_remaining != 0)
                        pr_remaining = pr_remaining - 30'd1;
                    if (pr_remaining == 0)
                        pr_phase = (pr_offset == 0) ? tsv_pkg::PH_HEADER : tsv_pkg::PH_PAD;
                    if (fin)
                        f = (pr_phase == tsv_pkg::PH_HEADER) ? tsv_pkg::F_NO_END
                                                              : tsv_pkg::F_TRUNC;
                end
                tsv_pkg::PH_PAD:
                begin
                    if (pr_offset == 0)
                        pr_phase = tsv_pkg::PH_HEADER;
                    if (fin)
                        f = (pr_phase == tsv_pkg::PH_HEADER) ? tsv_pkg::F_NO_END
                                                              : tsv_pkg::F_TRUNC;
                end
                default:
                begin
                    if (c != 0)
                        f = tsv_pkg::F_TRAIL;
                    else if (fin)
                    begin
                        r.kind = tsv_pkg::KIND_DONE;
                        have = 1'b1;
                    end
                end
            endcase
        end
        if (f != tsv_pkg::F_NONE)
        begin
            r = '0;
            r.kind  = tsv_pkg::KIND_ERROR;
            r.fault = f;
            have = 1'b1;
            pr_phase = tsv_pkg::PH_HALT;
        end
        if (fin)
            clear_stream();
        if (have)
            expected_q.push_back(r);
    endtask

    // ---------------- drivers ----------------
    task automatic send_beat(input logic [7:0] b, input bit fin);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        predict_byte(b, fin);
        beats_in++;
        if (fin)
            archives++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [29:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tsv_pkg::CFG_MAX_ENTRIES)
            lim_entries = val[19:0];
        else
            lim_bytes = val;
        @(posedge clk);
    endtask

    // ---------------- archive building ----------------
    // name_mode: 0 normal, 1 all spaces, 2 empty, 3 leading spaces then text
    // size_form: 0 zero padded, 1 space padded with junk after, 2 no digit, 3 bad digit
    task automatic make_header(input int name_mode, input logic [35:0] sz,
                               input int size_form, input logic [7:0] typ,
                               input bit corrupt_sum);
        int          len;
        logic [16:0] sum;
        for (int i = 0; i < 512; i++)
            hdr[i] = 8'($urandom_range(0, 255));
        case (name_mode)
            0:
            begin
                len = $urandom_range(1, 100);
                for (int i = 0; i < len; i++)
                    hdr[i] = 8'($urandom_range(33, 126));
                if (len < 100)
                    hdr[len] = tsv_pkg::CH_NUL;
            end
            1: for (int i = 0; i < 100; i++) hdr[i] = tsv_pkg::CH_SPACE;
            2: hdr[0] = tsv_pkg::CH_NUL;
            default:
            begin
                for (int i = 0; i < 5; i++) hdr[i] = tsv_pkg::CH_SPACE;
                hdr[5] = "a";
            end
        endcase
        case (size_form)
            0:
            begin
                for (int i = 0; i < 11; i++)
                    hdr[124 + i] = tsv_pkg::CH_ZERO + 8'((sz >> (3 * (10 - i))) & 7);
                hdr[135] = tsv_pkg::CH_NUL;
            end
            1:
            begin
                hdr[124] = tsv_pkg::CH_SPACE;
                hdr[125] = tsv_pkg::CH_NUL;
                hdr[126] = tsv_pkg::CH_SPACE;
                for (int i = 0; i < 7; i++)
                    hdr[127 + i] = tsv_pkg::CH_ZERO + 8'((sz >> (3 * (6 - i))) & 7);
                hdr[134] = tsv_pkg::CH_SPACE;
                hdr[135] = "x";
            end
            2: for (int i = 124; i < 136; i++) hdr[i] = tsv_pkg::CH_NUL;
            default:
            begin
                for (int i = 124; i < 135; i++) hdr[i] = tsv_pkg::CH_ZERO;
                hdr[130] = "9";
                hdr[135] = tsv_pkg::CH_NUL;
            end
        endcase
        hdr[156] = typ;
        sum = '0;
        for (int i = 0; i < 512; i++)
            sum = sum + ((i >= 148 && i < 156) ? 17'd32 : 17'(hdr[i]));
        if (corrupt_sum)
            sum = sum + 17'd1;
        for (int i = 0; i < 6; i++)
            hdr[148 + i] = tsv_pkg::CH_ZERO + 8'((sum >> (3 * (5 - i))) & 7);
        hdr[154] = tsv_pkg::CH_NUL;
        hdr[155] = tsv_pkg::CH_SPACE;
    endtask

    task automatic send_header(input bit fin);
        for (int i = 0; i < 512; i++)
            send_beat(hdr[i], fin && i == 511);
    endtask

    // payload plus padding; stops early with end set when cut_at >= 0
    task automatic send_payload(input int sz, input int cut_at);
        int total;
        total = ((sz + 511) / 512) * 512;
        for (int i = 0; i < total; i++)
        begin
            send_beat(8'($urandom_range(0, 255)), i == cut_at);
            if (i == cut_at)
                return;
        end
    endtask

    task automatic send_zero_block(input bit fin);
        for (int i = 0; i < 512; i++)
            send_beat(tsv_pkg::CH_NUL, fin && i == 511);
    endtask

    task automatic send_end(input int trail);
        send_zero_block(1'b0);
        send_zero_block(trail == 0);
        for (int i = 0; i < trail; i++)
            send_beat(tsv_pkg::CH_NUL, i == trail - 1);
    endtask

    task automatic send_entry(input logic [35:0] sz, input logic [7:0] typ, input int form);
        make_header(0, sz, form, typ, 1'b0);
        send_header(1'b0);
        send_payload(int'(sz), -1);
    endtask

    // ---------------- tests ----------------
    task automatic test_valid_archives();
        send_entry(36'd0, tsv_pkg::CH_NUL, 0);
        send_entry(36'd700, tsv_pkg::CH_ZERO, 1);
        send_entry(36'd512, tsv_pkg::CH_ZERO, 0);
        make_header(3, 36'd0, 0, tsv_pkg::CH_FIVE, 1'b0);
        send_header(1'b0);
        send_end(0);
        send_entry(36'd1, tsv_pkg::CH_ZERO, 0);
        send_end(3);
        wait_idle();
    endtask

    task automatic test_header_faults();
        make_header(0, 36'd10, 0, tsv_pkg::CH_ZERO, 1'b1);
        send_header(1'b0);
        send_beat(8'hff, 1'b1);
        make_header(1, 36'd10, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b1);
        make_header(2, 36'd10, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b1);
        make_header(0, 36'd10, 2, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b1);
        make_header(0, 36'd10, 3, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b1);
        make_header(0, 36'd4, 0, tsv_pkg::CH_FIVE, 1'b0);
        send_header(1'b1);
        make_header(0, 36'd0, 0, "L", 1'b0);
        send_header(1'b1);
        make_header(0, 36'd0, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b1);
        make_header(0, 36'd9, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b1);
        make_header(0, 36'hFFFFFFFFF, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b1);
        wait_idle();
    endtask

    task automatic test_early_end();
        make_header(0, 36'd100, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b0);
        send_payload(100, 50);
        make_header(0, 36'd100, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b0);
        send_payload(100, 300);
        make_header(0, 36'd512, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b0);
        send_payload(512, 511);
        send_zero_block(1'b1);
        for (int i = 0; i < 40; i++)
            send_beat(tsv_pkg::CH_NUL, i == 39);
        send_beat(8'h00, 1'b1);
        send_zero_block(1'b0);
        send_zero_block(1'b0);
        send_beat(tsv_pkg::CH_NUL, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h01, 1'b1);
        wait_idle();
    endtask

    task automatic test_limits();
        write_reg(tsv_pkg::CFG_MAX_ENTRIES, 30'd1);
        send_entry(36'd3, tsv_pkg::CH_ZERO, 0);
        send_entry(36'd3, tsv_pkg::CH_ZERO, 0);
        send_beat(8'h00, 1'b1);
        send_entry(36'd0, tsv_pkg::CH_ZERO, 0);
        send_end(0);
        wait_idle();
        write_reg(tsv_pkg::CFG_MAX_ENTRIES, 30'hFFFFF);
        write_reg(tsv_pkg::CFG_MAX_BYTES, 30'd512);
        send_entry(36'd0, tsv_pkg::CH_ZERO, 0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
        make_header(0, 36'd513, 0, tsv_pkg::CH_ZERO, 1'b0);
        send_header(1'b0);
        send_beat(8'h00, 1'b1);
        wait_idle();
        write_reg(tsv_pkg::CFG_MAX_BYTES, 30'd2048);
        send_entry(36'd600, tsv_pkg::CH_ZERO, 0);
        send_end(5);
        wait_idle();
        write_reg(tsv_pkg::CFG_MAX_BYTES, 30'h3FFFFFFF);
        send_entry(36'd20, tsv_pkg::CH_ZERO, 0);
        send_end(0);
        wait_idle();
    endtask

    task automatic send_random_archive();
        int          n;
        int          pick;
        logic [35:0] sz;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            n = $urandom_range(1, 700);
            for (int i = 0; i < n; i++)
                send_beat(8'($urandom_range(0, 255)), i == n - 1);
            return;
        end
        n = $urandom_range(1, 3);
        for (int e = 0; e < n; e++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                make_header($urandom_range(0, 3) == 0 ? 3 : 0, 36'd0, 0,
                            tsv_pkg::CH_FIVE, 1'b0);
                send_header(1'b0);
            end
            else
            begin
                sz = ($urandom_range(0, 9) < 7) ? 36'($urandom_range(0, 700))
                                                : 36'($urandom_range(701, 1600));
                send_entry(sz, $urandom_range(0, 1) ? tsv_pkg::CH_ZERO : tsv_pkg::CH_NUL,
                           $urandom_range(0, 1));
            end
        end
        if (pick == 1)
        begin
            make_header($urandom_range(0, 3), 36'($urandom_range(0, 40)),
                        $urandom_range(0, 3), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            send_header(1'b0);
            send_payload($urandom_range(1, 600), $urandom_range(0, 500));
        end
        else if (pick == 2)
        begin
            send_zero_block(1'b0);
            send_zero_block(1'b0);
            send_beat(8'($urandom_range(1, 255)), 1'b0);
            send_beat(tsv_pkg::CH_NUL, 1'b1);
        end
        else
            send_end($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
    endtask

    task automatic test_random_archives(input int count);
        for (int a = 0; a < count; a++)
        begin
            if (a == count - 3)
                calm = 1'b1;
            send_random_archive();
        end
        wait_idle();
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        tsv_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat, kind", m_tuser, -1);
            else
            begin
                want = expected_q.pop_front();
                if (m_tuser != want.kind)       report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[0] != want.is_dir)  report_mismatch("dir", m_tdata[0], want.is_dir);
                if (m_tdata[30:1] != want.length)
                    report_mismatch("length", m_tdata[30:1], want.length);
                if (m_tdata[50:31] != want.number)
                    report_mismatch("entry", m_tdata[50:31], want.number);
                if (m_tdata[58:51] != want.value)
                    report_mismatch("payload", m_tdata[58:51], want.value);
                if (m_tdata[62:59] != want.fault)
                    report_mismatch("fault", m_tdata[62:59], want.fault);
                if (m_tlast != want.final_byte)
                    report_mismatch("final", m_tlast, want.final_byte);
            end
        end
    end

    // output stalls
    always @(posedge clk)
    begin
        if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            m_tready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_stall <= $urandom_range(0, 3);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mismatches  = 0;
        beats_in    = 0;
        beats_out   = 0;
        archives    = 0;
        idle_cycles = 0;
        out_stall   = 0;
        calm        = 1'b0;
        lim_entries = tsv_pkg::MAX_ENTRIES_RST;
        lim_bytes   = tsv_pkg::MAX_BYTES_RST;
        clear_stream();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_archives();
        test_header_faults();
        test_early_end();
        test_limits();
        test_random_archives(14);

        repeat (8) @(posedge clk);
        $display("covered %0d streams, %0d input beats, %0d output beats",
                 archives, beats_in, beats_out);
        $display("header faults, early ends, trailing data, limits and noise exercised");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
